/* rtl/midi_note_pairing_macros.svh */
// Assertion macros shared by the note pairing RTL.
// The checks are compiled only for simulation; synthesis sees empty bodies.
`ifndef MIDI_NOTE_PAIRING_MACROS_SVH
`define MIDI_NOTE_PAIRING_MACROS_SVH

`ifndef SYNTHESIS

// Check that is ignored while reset is asserted.
`define MNP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("midi_note_pairing: assertion failed");

// Check that is evaluated on every clock edge, reset included.
`define MNP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("midi_note_pairing: assertion failed");

`else

`define MNP_ASSERT(label, prop)
`define MNP_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* rtl/mnp_pkg.sv */
package mnp_pkg;

    localparam int OPEN_NOTES_DEF = 64;

    localparam int TRACK_W = 8;
    localparam int CHAN_W  = 4;
    localparam int PITCH_W = 7;
    localparam int VEL_W   = 7;
    localparam int TIME_W  = 32;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;

    // Event action codes (input tuser).
    localparam logic ACT_NOTE_ON  = 1'b0;
    localparam logic ACT_NOTE_OFF = 1'b1;

    // Result kind codes (output tuser).
    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [CHAN_W-1:0]  channel;
        logic [TRACK_W-1:0] track;
    } t_key;

    // One entry of the open note table.
    typedef struct packed {
        logic              valid;
        t_key              key;
        logic [TIME_W-1:0] start;
    } t_entry;

    // Search token that walks along the cell chain.
    typedef struct packed {
        logic              valid;
        logic              done;
        logic [TIME_W-1:0] start;
    } t_pkt;

endpackage

/* rtl/midi_note_pairing.sv */
// Each accepted event sends a search token through all OPEN_NOTES cells of the open note table,
// one cell per cycle while the chain is not held, into r_exit and then to the output register.
// A new event is taken only as the previous token leaves r_exit; a result that is not taken
// holds the token at the exit and stalls the input.
// Reset (synchronous, active low) empties the table by clearing every cell's valid bit,
// drops any token in flight and any pending result; entry contents are not cleared.
`include "midi_note_pairing_macros.svh"

module midi_note_pairing
    import mnp_pkg::*;
#(
    parameter int OPEN_NOTES = OPEN_NOTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Event input.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [7:0] track, [11:8] channel, [18:12] pitch, [25:19] velocity,
    // [57:26] event_time, [63:58] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [0] action
    input  logic                 i_s_tuser,
    // Result output.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] note_track, [11:8] note_channel, [18:12] note_pitch,
    // [50:19] start_time, [82:51] duration, [87:83] zero
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // [0] result_kind
    output logic                 o_m_tuser
);

    // The open note table is a row of identical cells, oldest entry in cell 0 and
    // valid entries always packed at the low end. An accepted event is held in
    // r_key, r_time and r_is_on and broadcast to every cell, while a small token
    // enters cell 0 and moves up one cell per cycle unless the chain holds. A
    // note-on token claims the first empty cell. A note-off token captures the
    // start time of the first matching cell and marks itself done; every later
    // cell then slides down by one as the token passes, removing the closed entry.
    // After the last cell the token lands in r_exit, where the result is formed.

    t_key              r_key;
    logic [TIME_W-1:0] r_time;
    logic              r_is_on;
    logic              r_busy;
    t_pkt              r_exit;

    logic              r_out_valid;
    logic              r_out_kind;
    t_key              r_out_key;
    logic [TIME_W-1:0] r_out_start;
    logic [TIME_W-1:0] r_out_dur;

    logic              w_accept;
    logic              w_en;
    logic              w_exit_result;
    logic              w_event_on;
    t_pkt              w_in_pkt;
    t_entry            w_empty;

    t_pkt              w_fwd      [OPEN_NOTES];
    t_pkt              w_pkt      [OPEN_NOTES];
    t_entry            w_entry    [OPEN_NOTES];
    t_pkt              w_up_pkt   [OPEN_NOTES];
    t_entry            w_up_entry [OPEN_NOTES];
    t_pkt              w_prev_pkt [OPEN_NOTES];

    logic [OPEN_NOTES-1:0] w_valid;
    logic [OPEN_NOTES:0]   w_tok_vec;
    logic                  w_valid_packed;

    always_comb begin
        // A note-on with zero velocity behaves as a note-off.
        w_event_on = (i_s_tuser == ACT_NOTE_ON) && (i_s_tdata[25:19] != '0);

        // A result comes from a matched note-off or from a note-on that found no room.
        w_exit_result = r_is_on ? !r_exit.done : r_exit.done;

        // The whole chain holds while a new result would overwrite one not yet taken.
        w_en = !(r_exit.valid && w_exit_result && r_out_valid && !i_m_tready);

        // A new event may enter in the cycle the previous token leaves the chain.
        o_s_tready = !r_busy || (r_exit.valid && w_en);
        w_accept   = i_s_tvalid && o_s_tready;

        w_in_pkt.valid = w_accept;
        w_in_pkt.done  = 1'b0;
        w_in_pkt.start = '0;

        w_empty.valid = 1'b0;
        w_empty.key   = '0;
        w_empty.start = '0;
    end

    genvar g;
    generate
        for (g = 0; g < OPEN_NOTES; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev_pkt[g] = w_in_pkt;
            end else begin : g_mid
                assign w_prev_pkt[g] = w_fwd[g-1];
            end

            if (g == OPEN_NOTES - 1) begin : g_last
                assign w_up_pkt[g]   = r_exit;
                assign w_up_entry[g] = w_empty;
            end else begin : g_inner
                assign w_up_pkt[g]   = w_pkt[g+1];
                assign w_up_entry[g] = w_entry[g+1];
            end

            assign w_valid[g]   = w_entry[g].valid;
            assign w_tok_vec[g] = w_pkt[g].valid;

            mnp_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_en),
                .i_key      (r_key),
                .i_time     (r_time),
                .i_is_on    (r_is_on),
                .i_pkt_prev (w_prev_pkt[g]),
                .i_pkt_up   (w_up_pkt[g]),
                .i_entry_up (w_up_entry[g]),
                .o_entry    (w_entry[g]),
                .o_pkt      (w_pkt[g]),
                .o_fwd      (w_fwd[g])
            );
        end
    endgenerate

    assign w_tok_vec[OPEN_NOTES] = r_exit.valid;

    always_comb begin
        // Valid entries form a run starting at cell 0.
        w_valid_packed = (w_valid & (w_valid + {{(OPEN_NOTES-1){1'b0}}, 1'b1})) == '0;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_exit.valid <= 1'b0;
            r_exit.done  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_exit.valid && w_en) begin
                r_busy <= 1'b0;
            end

            if (w_en) begin
                r_exit.valid <= w_fwd[OPEN_NOTES-1].valid;
                r_exit.done  <= w_fwd[OPEN_NOTES-1].done;
            end

            if (r_exit.valid && w_exit_result && w_en) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key.track   <= i_s_tdata[7:0];
            r_key.channel <= i_s_tdata[11:8];
            r_key.pitch   <= i_s_tdata[18:12];
            r_time        <= i_s_tdata[57:26];
            r_is_on       <= w_event_on;
        end

        if (w_en) begin
            r_exit.start <= w_fwd[OPEN_NOTES-1].start;
        end

        if (r_exit.valid && w_exit_result && w_en) begin
            r_out_key <= r_key;
            if (r_is_on) begin
                // The table was full: report the dropped note-on.
                r_out_kind  <= KIND_DROP;
                r_out_start <= r_time;
                r_out_dur   <= '0;
            end else begin
                r_out_kind  <= KIND_NOTE;
                r_out_start <= r_exit.start;
                r_out_dur   <= r_time - r_exit.start;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {5'b0, r_out_dur, r_out_start,
                         r_out_key.pitch, r_out_key.channel, r_out_key.track};

    // Open entries always sit packed from cell 0 upward.
    `MNP_ASSERT(a_valid_packed, w_valid_packed)
    // At most one search token is in the chain or at its exit.
    `MNP_ASSERT(a_one_token, $onehot0(w_tok_vec))
    // No token moves while the block is idle.
    `MNP_ASSERT(a_idle_no_token, !r_busy |-> (w_tok_vec == '0))
    // A note-on is only dropped when every cell holds an open note.
    `MNP_ASSERT(a_drop_when_full, (r_exit.valid && r_is_on && !r_exit.done) |-> (&w_valid))
    // Nothing is offered on the output right after reset.
    `MNP_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_m_tvalid)

endmodule

/* rtl/mnp_cell.sv */
module mnp_cell
    import mnp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_key              i_key,
    input  logic [TIME_W-1:0] i_time,
    input  logic              i_is_on,
    input  t_pkt              i_pkt_prev,
    input  t_pkt              i_pkt_up,
    input  t_entry            i_entry_up,
    output t_entry            o_entry,
    output t_pkt              o_pkt,
    output t_pkt              o_fwd
);

    logic              r_valid;
    t_key              r_key;
    logic [TIME_W-1:0] r_start;
    t_pkt              r_pkt;

    logic w_hit;
    logic w_ins;
    logic w_shift;

    always_comb begin
        // A note-off token takes the first matching entry it meets; since entries
        // sit oldest first, that is the oldest open note of this key.
        w_hit = r_pkt.valid && !r_pkt.done && !i_is_on && r_valid && (r_key == i_key);
        // A note-on token fills the first free cell.
        w_ins = r_pkt.valid && !r_pkt.done && i_is_on && !r_valid;
        // Once a note-off token has matched, each cell it passes pulls its
        // upper neighbor down by one, closing the gap.
        w_shift = i_pkt_up.valid && i_pkt_up.done && !i_is_on;

        o_fwd.valid = r_pkt.valid;
        o_fwd.done  = r_pkt.done || w_hit || w_ins;
        o_fwd.start = w_hit ? r_start : r_pkt.start;

        o_entry.valid = r_valid;
        o_entry.key   = r_key;
        o_entry.start = r_start;
        o_pkt         = r_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pkt.valid <= 1'b0;
            r_pkt.done  <= 1'b0;
        end else if (i_en) begin
            r_pkt.valid <= i_pkt_prev.valid;
            r_pkt.done  <= i_pkt_prev.done;
            if (w_ins) begin
                r_valid <= 1'b1;
            end else if (w_shift) begin
                r_valid <= i_entry_up.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pkt.start <= i_pkt_prev.start;
            if (w_ins) begin
                r_key   <= i_key;
                r_start <= i_time;
            end else if (w_shift) begin
                r_key   <= i_entry_up.key;
                r_start <= i_entry_up.start;
            end
        end
    end

endmodule

/* test/midi_note_pairing_checker.sv */
`timescale 1ns / 100ps

// Watches both stream channels of the note pairing block. Every event taken on the
// slave side updates a private table of open notes and may queue one expected
// result. Every result taken on the master side is compared with the oldest one.
module midi_note_pairing_checker
    import mnp_pkg::*;
#(
    parameter int OPEN_NOTES = OPEN_NOTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // [7:0] track, [11:8] channel, [18:12] pitch, [25:19] velocity,
    // [57:26] event_time, [63:58] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [0] action
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] note_track, [11:8] note_channel, [18:12] note_pitch,
    // [50:19] start_time, [82:51] duration, [87:83] zero
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // [0] result_kind
    input  logic                 i_m_tuser,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic              kind;
        t_key              key;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] span;
    } t_note_out;

    typedef struct packed {
        t_key              key;
        logic [TIME_W-1:0] start;
    } t_held_note;

    t_held_note held_q[$];  // open notes, oldest first
    t_note_out  due_q[$];   // results still to come, oldest first
    int         fails = 0;

    assign o_fail_count = fails;

    task automatic flag(input string why);
        if (fails < 10) begin
            $display("%0t checker: %s", $realtime, why);
        end
        fails++;
    endtask

    task automatic pair_event(input logic act, input t_key key,
                              input logic [VEL_W-1:0] vel, input logic [TIME_W-1:0] t);
        int         hit;
        t_note_out  res;
        t_held_note slot;
        hit = -1;
        res.key = key;
        if (act == ACT_NOTE_ON && vel != '0) begin
            if (held_q.size() >= OPEN_NOTES) begin
                res.kind  = KIND_DROP;
                res.start = t;
                res.span  = '0;
                due_q.push_back(res);
            end else begin
                slot.key   = key;
                slot.start = t;
                held_q.push_back(slot);
            end
        end else begin
            // A note-off, or a note-on of velocity zero, closes the oldest match.
            foreach (held_q[i]) begin
                if (hit < 0 && held_q[i].key == key) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                res.kind  = KIND_NOTE;
                res.start = held_q[hit].start;
                res.span  = t - held_q[hit].start;
                due_q.push_back(res);
                held_q.delete(hit);
            end
        end
    endtask

    task automatic check_result();
        t_note_out got;
        t_note_out want;
        got.kind  = i_m_tuser;
        got.key   = i_m_tdata[18:0];
        got.start = i_m_tdata[50:19];
        got.span  = i_m_tdata[82:51];
        if (due_q.size() == 0) begin
            flag($sformatf("unexpected result kind=%0d key=%h start=%h dur=%h",
                           got.kind, got.key, got.start, got.span));
        end else begin
            want = due_q.pop_front();
            if (got.kind !== want.kind || got.key.track !== want.key.track ||
                got.key.channel !== want.key.channel || got.key.pitch !== want.key.pitch ||
                got.start !== want.start || got.span !== want.span ||
                i_m_tdata[87:83] !== '0) begin
                flag($sformatf({"mismatch: expected kind=%0d trk=%h ch=%h pit=%h start=%h ",
                                "dur=%h, got kind=%0d trk=%h ch=%h pit=%h start=%h dur=%h ",
                                "pad=%h"},
                               want.kind, want.key.track, want.key.channel, want.key.pitch,
                               want.start, want.span, got.kind, got.key.track,
                               got.key.channel, got.key.pitch, got.start, got.span,
                               i_m_tdata[87:83]));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_q.delete();
            due_q.delete();
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                pair_event(i_s_tuser, i_s_tdata[18:0], i_s_tdata[25:19], i_s_tdata[57:26]);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
            o_pending <= due_q.size();
        end
    end

endmodule

/* test/midi_note_pairing_tb.sv */
`timescale 1ns / 100ps

// Top of the note pairing testbench. It only makes stimulus and gives the verdict;
// the checker instance beside the block predicts and compares every transaction.
module midi_note_pairing_tb;
    import mnp_pkg::*;

    // The block walks a search token through every cell before it accepts the
    // next event.
    localparam int SETTLE    = 2 * (OPEN_NOTES_DEF + 2);
    localparam int RAND_ITEMS = 650;
    // The receiver's long hold-off, in cycles after the start of the run.
    localparam int HOLD_AT   = 20000;
    localparam int HOLD_LEN  = 1500;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;

    int   fail_count;
    int   pending;
    // While set, neither side idles at random.
    logic calm = 1'b0;

    // Stimulus-side copy of the open keys, oldest first. It only steers the
    // choice of note-offs toward notes that are really open.
    t_key live_keys[$];
    logic [TIME_W-1:0] tick = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    midi_note_pairing i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    midi_note_pairing_checker u_pairing_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_key key_of(input logic [TRACK_W-1:0] trk,
                                    input logic [CHAN_W-1:0] chn,
                                    input logic [PITCH_W-1:0] pit);
        t_key k;
        k.track   = trk;
        k.channel = chn;
        k.pitch   = pit;
        return k;
    endfunction

    // Half of the new keys come from a tiny pool, so duplicates and near misses
    // in a single field are common; the rest are fully random.
    function automatic t_key fresh_key();
        if ($urandom_range(1) == 0) begin
            return key_of(TRACK_W'($urandom_range(3)), CHAN_W'($urandom_range(1)),
                          PITCH_W'(60 + $urandom_range(3)));
        end
        return key_of(TRACK_W'($urandom()), CHAN_W'($urandom()), PITCH_W'($urandom()));
    endfunction

    // Mostly a slowly rising tick count, now and then a jump anywhere, so that
    // durations wrap around as well.
    function automatic logic [TIME_W-1:0] next_time();
        if ($urandom_range(9) == 0) begin
            return $urandom();
        end
        tick = tick + $urandom_range(500);
        return tick;
    endfunction

    // Offers one event and returns at the edge where its transaction completes.
    // The valid line is only ever assigned once per time step.
    task automatic play(input logic act, input t_key key,
                        input logic [VEL_W-1:0] vel, input logic [TIME_W-1:0] t);
        int hit;
        while (!calm && $urandom_range(99) < 19) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {6'b0, t, vel, key};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        // Keep the stimulus-side key list in step with the block's table.
        hit = -1;
        if (act == ACT_NOTE_ON && vel != '0) begin
            if (live_keys.size() < OPEN_NOTES_DEF) begin
                live_keys.push_back(key);
            end
        end else begin
            foreach (live_keys[i]) begin
                if (hit < 0 && live_keys[i] == key) begin
                    hit = i;
                end
            end
            if (hit >= 0) begin
                live_keys.delete(hit);
            end
        end
    endtask

    // Closes a randomly chosen open note, either by a note-off with any velocity
    // or by a note-on of velocity zero. Closing from the middle of the table
    // makes the block compact its cells.
    task automatic close_random();
        t_key key;
        key = live_keys[$urandom_range(live_keys.size() - 1)];
        if ($urandom_range(9) < 3) begin
            play(ACT_NOTE_ON, key, '0, next_time());
        end else begin
            play(ACT_NOTE_OFF, key, VEL_W'($urandom()), next_time());
        end
    endtask

    // Opens notes until the table is full, then offers two more that must be
    // dropped and flagged.
    task automatic fill_table();
        while (live_keys.size() < OPEN_NOTES_DEF) begin
            play(ACT_NOTE_ON, fresh_key(), VEL_W'($urandom_range(1, 127)), next_time());
        end
        repeat (2) begin
            play(ACT_NOTE_ON, fresh_key(), VEL_W'($urandom_range(1, 127)), next_time());
        end
    endtask

    // The sender stops offering until every expected result has arrived, then
    // allows for a search that ends without a result.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Receiver: random backpressure, one long hold-off that makes the block
    // fill up and stall its input, and no idling while the calm window is open.
    initial begin : ready_driver
        int unsigned cyc;
        cyc = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
                i_m_tready <= 1'b0;
            end else if (calm) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 19);
            end
        end
    end

    initial begin : stimulus
        t_key ka;
        t_key kb;
        t_key kc;
        t_key kd;
        int   pick;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= ACT_NOTE_ON;
        i_s_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Keys at both extremes and with alternating bit patterns.
        ka = key_of(8'h00, 4'h0, 7'h00);
        kb = key_of(8'hFF, 4'hF, 7'h7F);
        kc = key_of(8'h5A, 4'hA, 7'h55);
        kd = key_of(8'hA5, 4'h5, 7'h2A);
        play(ACT_NOTE_ON,  ka, 7'd1,   32'd0);
        play(ACT_NOTE_ON,  kb, 7'h7F,  32'hFFFF_FFF0);
        play(ACT_NOTE_ON,  ka, 7'd64,  32'd5);
        // A note-off carries a velocity that must be ignored; it closes the older A.
        play(ACT_NOTE_OFF, ka, 7'h7F,  32'd10);
        // Velocity zero turns a note-on into a note-off.
        play(ACT_NOTE_ON,  ka, 7'd0,   32'd20);
        // Off time below the start time: the duration wraps.
        play(ACT_NOTE_OFF, kb, 7'd0,   32'h0000_0010);
        // Unmatched note-off and unmatched zero-velocity note-on give nothing.
        play(ACT_NOTE_OFF, ka, 7'h55,  32'd30);
        play(ACT_NOTE_ON,  kb, 7'd0,   32'd31);
        // A duration of all ones still closes the note.
        play(ACT_NOTE_ON,  kc, 7'h2A,  32'd100);
        play(ACT_NOTE_OFF, kc, 7'h2A,  32'd99);
        // Zero duration at the top of the time range.
        play(ACT_NOTE_ON,  kd, 7'h55,  32'hFFFF_FFFF);
        play(ACT_NOTE_OFF, kd, 7'h55,  32'hFFFF_FFFF);
        // Keys that differ from an open one in a single field must not match.
        play(ACT_NOTE_ON,  key_of(8'd3, 4'd4, 7'd5), 7'd90, 32'd1000);
        play(ACT_NOTE_ON,  key_of(8'd3, 4'd4, 7'd6), 7'd91, 32'd1001);
        play(ACT_NOTE_OFF, key_of(8'd3, 4'd4, 7'd7), 7'd0,  32'd1002);
        play(ACT_NOTE_OFF, key_of(8'd3, 4'd5, 7'd5), 7'd0,  32'd1003);
        play(ACT_NOTE_OFF, key_of(8'd4, 4'd4, 7'd5), 7'd0,  32'd1004);
        // Closing the older entry first makes the table compact.
        play(ACT_NOTE_OFF, key_of(8'd3, 4'd4, 7'd5), 7'd1,  32'd1020);
        play(ACT_NOTE_OFF, key_of(8'd3, 4'd4, 7'd6), 7'd1,  32'd1030);
        i_s_tvalid <= 1'b0;
        drain();

        // Full table: fill it, overflow it, then empty it in random order.
        fill_table();
        while (live_keys.size() > 0) begin
            close_random();
        end
        i_s_tvalid <= 1'b0;
        drain();

        // Random part: mostly open/close traffic on live keys, some noise, and
        // two bursts that push the table to full again.
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm <= (n >= 400 && n < 550);
            if (n == 300 || n == 600) begin
                fill_table();
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                if (live_keys.size() > 0 && $urandom_range(9) < 3) begin
                    play(ACT_NOTE_ON, live_keys[$urandom_range(live_keys.size() - 1)],
                         VEL_W'($urandom_range(1, 127)), next_time());
                end else begin
                    play(ACT_NOTE_ON, fresh_key(), VEL_W'($urandom_range(1, 127)),
                         next_time());
                end
            end else if (pick < 85 && live_keys.size() > 0) begin
                close_random();
            end else begin
                play(1'($urandom()), fresh_key(), VEL_W'($urandom()), $urandom());
            end
        end
        i_s_tvalid <= 1'b0;
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mnp_pkg.sv
rtl/mnp_cell.sv
rtl/midi_note_pairing.sv
test/midi_note_pairing_checker.sv
test/midi_note_pairing_tb.sv
